// ===== sv/dpp_pkg.sv =====
// Shared types and constants of the deadline pool.
`default_nettype none

package dpp_pkg;

  localparam int unsigned DPP_ENTRIES    = 16;
  localparam int unsigned DPP_VALUE_BITS = 32;
  localparam int unsigned PAYLOAD_BITS   = 32;
  localparam int unsigned TIME_BITS      = 48;
  localparam int unsigned OCC_BITS       = 5;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_POLL   = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_POPPED   = 2'd0,
    ST_NONE     = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_MOVE,
    S_RESP
  } state_e;

  typedef struct packed {
    action_e                 action;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [TIME_BITS-1:0]    time_ms;
  } dpp_in_t;

  typedef struct packed {
    status_e                 status;
    logic [PAYLOAD_BITS-1:0] popped_value;
    logic [OCC_BITS-1:0]     occupancy;
  } dpp_out_t;

endpackage

`default_nettype wire

// ===== sv/dpp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module dpp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/deadline_pool_pop.sv =====
// Top level of the deadline pool: slot memory, scan sequencer and result register.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------
//   in      | input     | in_valid_i / in_ready_o | in_req_i  (action, payload, time)
//   out     | output    | out_valid_o/out_ready_i | out_rsp_o (status, value, count)
//
// An insert, or a poll of an empty pool, is accepted, then the result moves to the output
// register. A poll over N pairs scans the slots in order (one slot read and one 48-bit
// compare per cycle on the single read port); on a hit, S_FETCH reads the last pair and
// S_MOVE writes it into the freed slot, and S_RESP then hands the result over. Reset
// clears the pair count and the control state; slot contents are not cleared. Input is
// ready only in idle; a waiting result stalls the sequencer only when a second is due.
`default_nettype none

module deadline_pool_pop
  import dpp_pkg::*;
#(
  parameter int unsigned ENTRIES    = DPP_ENTRIES,
  parameter int unsigned VALUE_BITS = DPP_VALUE_BITS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dpp_in_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output dpp_out_t      out_rsp_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned MEM_W = TIME_BITS + VALUE_BITS;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     scan_q, scan_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [VALUE_BITS-1:0] popped_q, popped_d;
  dpp_out_t             res_q, res_d;
  dpp_out_t             out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [MEM_W-1:0]     mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  logic [MEM_W-1:0]     mem_rdata;

  logic                 accept;
  logic                 out_free;
  logic                 hit;
  logic                 at_last;
  logic [CNT_W-1:0]     last_idx;

  // Each memory word holds the deadline above the stored value.
  dpp_ram #(
    .WIDTH (MEM_W),
    .DEPTH (ENTRIES)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // The shared comparator: the current time against the deadline just read.
  assign hit      = (time_q >= mem_rdata[MEM_W-1 -: TIME_BITS]);
  assign last_idx = count_q - CNT_W'(1);
  assign at_last  = (CNT_W'(cmp_idx_q) == last_idx);

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_req_i.action == ACT_POLL && count_q != '0) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (cmp_vld_q && hit) begin
          state_d = S_FETCH;
        end else if (cmp_vld_q && at_last) begin
          state_d = S_RESP;
        end
      end
      S_FETCH: state_d = S_MOVE;
      S_MOVE:  state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory control and result register.
  always_comb begin
    count_d     = count_q;
    scan_d      = scan_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    hit_idx_d   = hit_idx_q;
    time_d      = time_q;
    popped_d    = popped_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = count_q[IDX_W-1:0];
    mem_wdata   = {in_req_i.time_ms, VALUE_BITS'(in_req_i.payload)};
    mem_raddr   = scan_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          time_d             = in_req_i.time_ms;
          scan_d             = '0;
          cmp_vld_d          = 1'b0;
          res_d.popped_value = '0;
          res_d.occupancy    = OCC_BITS'(count_q);
          if (in_req_i.action == ACT_INSERT) begin
            if (count_q >= CNT_W'(ENTRIES)) begin
              res_d.status = ST_FULL;
            end else begin
              mem_we          = 1'b1;
              count_d         = count_q + CNT_W'(1);
              res_d.status    = ST_INSERTED;
              res_d.occupancy = OCC_BITS'(count_q + CNT_W'(1));
            end
          end else begin
            // An empty pool answers at once.
            res_d.status = ST_NONE;
          end
        end
      end
      S_SCAN: begin
        // Issue the next slot read while comparing the one read last cycle.
        if (scan_q != count_q) begin
          scan_d = scan_q + CNT_W'(1);
        end
        cmp_vld_d = (scan_q != count_q);
        cmp_idx_d = scan_q[IDX_W-1:0];
        if (cmp_vld_q && hit) begin
          hit_idx_d = cmp_idx_q;
          popped_d  = mem_rdata[VALUE_BITS-1:0];
        end else if (cmp_vld_q && at_last) begin
          res_d.status       = ST_NONE;
          res_d.popped_value = '0;
          res_d.occupancy    = OCC_BITS'(count_q);
        end
      end
      S_FETCH: begin
        mem_raddr = last_idx[IDX_W-1:0];
      end
      S_MOVE: begin
        // The last pair fills the freed slot; when they coincide the write is harmless.
        mem_we             = 1'b1;
        mem_waddr          = hit_idx_q;
        mem_wdata          = mem_rdata;
        count_d            = last_idx;
        res_d.status       = ST_POPPED;
        res_d.popped_value = PAYLOAD_BITS'(popped_q);
        res_d.occupancy    = OCC_BITS'(last_idx);
      end
      S_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    hit_idx_q <= hit_idx_d;
    time_q    <= time_d;
    popped_q  <= popped_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

endmodule

`default_nettype wire

// ===== sv/dpp_checker.sv =====
// Port-level assertions for the deadline pool and their bind to the top level.
`default_nettype none

module dpp_checker
  import dpp_pkg::*;
#(
  parameter int unsigned ENTRIES = DPP_ENTRIES
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire dpp_out_t out_rsp_o
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed or vanished while stalled");

  // Only a pop carries a value.
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_POPPED |-> out_rsp_o.popped_value == '0)
    else $error("value reported on a result that popped nothing");

  // A rejected insert means the pool is at capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == ST_FULL |-> out_rsp_o.occupancy == OCC_BITS'(ENTRIES))
    else $error("full status with a pool below capacity");

  // A taken request moves the sequencer out of idle, so input is not ready right after it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a request was taken");

endmodule

bind deadline_pool_pop dpp_checker #(
  .ENTRIES (ENTRIES)
) u_dpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

// ===== sim/deadline_pool_pop_test.sv =====
// Self-checking testbench for the deadline pool: directed, random and backpressure runs.
`default_nettype none

module deadline_pool_pop_test;
  import dpp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam time RUN_LIMIT = 2_000_000ns;
  localparam int  TAIL_CYCLES = 40;     // longer than the slowest full-pool scan
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  dpp_in_t  in_req;
  logic     out_valid;
  logic     out_ready;
  dpp_out_t out_rsp;

  deadline_pool_pop dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Our own copy of the pool. Only slots below pool_count are ever read, so the
  // slot contents need no reset value.
  logic [DPP_VALUE_BITS-1:0] pool_value [DPP_ENTRIES];
  logic [TIME_BITS-1:0]      pool_deadline [DPP_ENTRIES];
  int unsigned               pool_count;

  dpp_out_t expected_outcomes [$];
  int       mismatch_count;

  // Shared knobs between the test sequence and the receiver process.
  bit gaps_on;          // random idle cycles on both sides
  int hold_request;     // a long receiver hold-off, picked up by the receiver

  logic [TIME_BITS-1:0] now_ms;   // the notional wall clock used by random requests

  // Applies one accepted request to the pool copy and returns the result it must
  // produce. Inserts append at the tail; a poll scans in slot order for the first
  // expired deadline and fills the hole with the last pair.
  function automatic dpp_out_t apply_to_pool(dpp_in_t req);
    dpp_out_t rsp;
    int unsigned last;
    rsp.status       = ST_NONE;
    rsp.popped_value = '0;
    if (req.action == ACT_INSERT) begin
      if (pool_count >= DPP_ENTRIES) begin
        rsp.status = ST_FULL;
      end else begin
        pool_value[pool_count]    = req.payload[DPP_VALUE_BITS-1:0];
        pool_deadline[pool_count] = req.time_ms;
        pool_count++;
        rsp.status = ST_INSERTED;
      end
    end else begin
      for (int unsigned i = 0; i < pool_count; i++) begin
        if (req.time_ms >= pool_deadline[i]) begin
          last                 = pool_count - 1;
          rsp.popped_value     = PAYLOAD_BITS'(pool_value[i]);
          pool_value[i]        = pool_value[last];
          pool_deadline[i]     = pool_deadline[last];
          pool_count           = last;
          rsp.status           = ST_POPPED;
          break;
        end
      end
    end
    rsp.occupancy = OCC_BITS'(pool_count);
    return rsp;
  endfunction

  function automatic logic [TIME_BITS-1:0] any_time();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[TIME_BITS-1:0];
  endfunction

  // Offers one request. Inputs move only at the falling edge; when no gap is drawn,
  // valid simply stays high and the next payload replaces the accepted one.
  task automatic send_request(action_e act, logic [PAYLOAD_BITS-1:0] value,
                              logic [TIME_BITS-1:0] t);
    int gap;
    dpp_in_t req;
    gap         = gaps_on ? $urandom_range(0, 5) : 0;
    req.action  = act;
    req.payload = value;
    req.time_ms = t;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req   <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_outcomes.push_back(apply_to_pool(req));
  endtask

  // Random request around the running clock. Most deadlines land a few ms ahead
  // so that polls find some pairs expired and some not; one in sixteen times is
  // drawn from the whole 48-bit range to move every bit.
  task automatic send_random_request(int insert_pct);
    logic [TIME_BITS-1:0] t;
    now_ms = now_ms + TIME_BITS'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < insert_pct) begin
      t = ($urandom_range(0, 15) == 0) ? any_time()
                                       : now_ms + TIME_BITS'($urandom_range(0, 40));
      send_request(ACT_INSERT, $urandom(), t);
    end else begin
      t = ($urandom_range(0, 15) == 0) ? any_time() : now_ms;
      send_request(ACT_POLL, $urandom(), t);
    end
  endtask

  // Result side. The receiver decides its ready level at every falling edge, so
  // ready gets exactly one assignment per step. A stall is drawn after each taken
  // result, and a requested hold-off is counted down here, in cycles.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (out_valid && out_ready) stall_left = gaps_on ? $urandom_range(0, 5) : 0;
    end
  end

  // Every taken result is matched against the oldest expectation.
  always @(posedge clk) begin
    dpp_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_outcomes.size() == 0) begin
        $error("unexpected result: status %0d value %0h occupancy %0d",
               out_rsp.status, out_rsp.popped_value, out_rsp.occupancy);
        mismatch_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_rsp.status);
          mismatch_count++;
        end
        if (out_rsp.popped_value !== want.popped_value) begin
          $error("popped_value: expected %0h, got %0h",
                 want.popped_value, out_rsp.popped_value);
          mismatch_count++;
        end
        if (out_rsp.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, out_rsp.occupancy);
          mismatch_count++;
        end
      end
    end
  end

  // Hand-picked requests: polls on an empty pool, field extremes, a pop from the
  // middle of the pool that pulls the last pair forward, a poll where nothing has
  // expired, and inserts into a full pool that must be refused.
  task automatic test_directed();
    send_request(ACT_POLL, '0, '0);
    send_request(ACT_POLL, '1, TIME_MAX);
    send_request(ACT_INSERT, '0, TIME_MAX);
    send_request(ACT_INSERT, '1, '0);
    send_request(ACT_INSERT, 32'hA5A5_5A5A, 48'd1000);
    send_request(ACT_POLL, 32'h1234_5678, '0);
    send_request(ACT_POLL, '0, 48'd999);
    send_request(ACT_POLL, '0, TIME_MAX);
    for (int i = 0; i < DPP_ENTRIES - 1; i++) begin
      send_request(ACT_INSERT, $urandom(), TIME_BITS'(i) << (3 * i));
    end
    send_request(ACT_INSERT, '1, '0);
    send_request(ACT_INSERT, '0, TIME_MAX);
  endtask

  // Long random run in phases that lean toward inserts, toward polls or neither, so the
  // pool swings between empty and full with gaps on both sides.
  task automatic test_random_traffic(int count);
    int insert_pct;
    insert_pct = 50;
    now_ms = any_time() >> 1;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 25;
          1: insert_pct = 50;
          default: insert_pct = 80;
        endcase
      end
      send_random_request(insert_pct);
    end
  endtask

  // Back-to-back requests and results with no idle cycles inserted on either side.
  task automatic test_back_to_back(int count);
    gaps_on = 1'b0;
    now_ms  = '0;
    for (int i = 0; i < count; i++) send_random_request(55);
    gaps_on = 1'b1;
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // output register fills and the block has to hold off its input.
  task automatic test_output_stall(int count);
    gaps_on      = 1'b0;
    hold_request = 80;
    for (int i = 0; i < count; i++) send_random_request(60);
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req         = '0;
    gaps_on        = 1'b1;
    hold_request   = 0;
    mismatch_count = 0;
    pool_count     = 0;
    now_ms         = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(1000);
    test_back_to_back(250);
    test_output_stall(60);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== deadline_pool_pop.f =====
sv/dpp_pkg.sv
sv/dpp_ram.sv
sv/deadline_pool_pop.sv
sv/dpp_checker.sv
sim/deadline_pool_pop_test.sv
